// ===== sv/bta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg: shared types and constants for the boundary tag heap allocator
// Request/result structs, status codes, datapath command and status types.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned HeapBytesDef = 65536;
  localparam int unsigned WordBytesDef = 4;

  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StNoFit  = 2'd1;
  localparam logic [1:0] StZero   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_bytes;
    logic [15:0] release_address;
  } bta_req_t;

  typedef struct packed {
    logic [15:0] payload_address;
    logic [1:0]  status;
  } bta_rsp_t;

  // memory access command from controller to datapath
  typedef struct packed {
    logic        rd;       // read word at addr (data valid next cycle)
    logic        wr;       // write data to addr
    logic [31:0] addr;     // byte address
    logic [31:0] data;
  } bta_mem_cmd_t;

  typedef struct packed {
    logic [31:0] rdata;    // registered read data, zero beyond the heap
  } bta_mem_sts_t;

endpackage

// ===== sv/bta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bta_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== sv/bta_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_datapath: heap word memory with range checking
// Maps byte addresses to words; out-of-range reads give zero, writes drop.
// ----------------------------------------------------------------------------
module bta_datapath #(
  parameter int unsigned HeapBytes = 65536,
  parameter int unsigned WordBytes = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bta_pkg::bta_mem_cmd_t cmd_i,
  output bta_pkg::bta_mem_sts_t sts_o
);
  import bta_pkg::*;

  localparam int unsigned HeapWords = HeapBytes / WordBytes;
  localparam int unsigned AddrW = $clog2(HeapWords);
  localparam int unsigned ShW = $clog2(WordBytes);

  logic [31:0]      word_idx;
  logic             in_range;
  logic             in_range_q;
  logic [31:0]      ram_rdata;

  assign word_idx = cmd_i.addr >> ShW;
  assign in_range = word_idx < 32'(HeapWords);

  bta_ram #(.Width(32), .Depth(HeapWords)) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr && in_range),
    .addr_i (word_idx[AddrW-1:0]),
    .wdata_i(cmd_i.data),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
    end else begin
      in_range_q <= in_range;
    end
  end

  assign sts_o.rdata = in_range_q ? ram_rdata : 32'd0;
endmodule

// ===== sv/bta_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ctrl: allocator sequencer
// Walks the free list, splits, merges and links blocks with at most one memory access
// per cycle through the datapath.
// ----------------------------------------------------------------------------
module bta_ctrl #(
  parameter int unsigned HeapBytes = 65536,
  parameter int unsigned WordBytes = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_stall_o,
  input  bta_pkg::bta_req_t     req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_stall_i,
  output bta_pkg::bta_rsp_t     rsp_o,
  output bta_pkg::bta_mem_cmd_t cmd_o,
  input  bta_pkg::bta_mem_sts_t sts_i
);
  import bta_pkg::*;

  localparam int unsigned HeapWords = HeapBytes / WordBytes;
  localparam logic [31:0] Wb   = 32'(WordBytes);
  localparam logic [31:0] Wb2  = 32'(2 * WordBytes);
  localparam logic [31:0] MinB = 32'(4 * WordBytes);
  localparam logic [31:0] Total = 32'((HeapBytes / WordBytes) * WordBytes);
  localparam logic [31:0] HBytes = 32'(HeapBytes);
  localparam logic [31:0] WMask = ~(Wb - 32'd1);
  localparam int unsigned StepW = $clog2(HeapWords + 2) + 1;

  // states
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_FMT0   = 6'd1;  // header
  localparam logic [5:0] S_FMT1   = 6'd2;  // footer
  localparam logic [5:0] S_WLK0   = 6'd5;  // read header of n
  localparam logic [5:0] S_WLK1   = 6'd6;  // check size, read next
  localparam logic [5:0] S_WLK2   = 6'd7;  // take next
  localparam logic [5:0] S_TK0    = 6'd8;  // write remainder footer
  localparam logic [5:0] S_TK1    = 6'd9;  // read next block header
  localparam logic [5:0] S_TK2    = 6'd10;
  localparam logic [5:0] S_TK3    = 6'd11; // tags
  localparam logic [5:0] S_TK4    = 6'd12;
  localparam logic [5:0] S_TK5    = 6'd13;
  localparam logic [5:0] S_TK6    = 6'd14;
  localparam logic [5:0] S_RL0    = 6'd15; // read header of rel
  localparam logic [5:0] S_RL1    = 6'd16; // write header
  localparam logic [5:0] S_RL2    = 6'd17; // write footer
  localparam logic [5:0] S_MG0    = 6'd18; // re-read header
  localparam logic [5:0] S_MG1    = 6'd19; // read prev footer
  localparam logic [5:0] S_MG2    = 6'd20; // read next header
  localparam logic [5:0] S_MG3    = 6'd21; // decide
  localparam logic [5:0] S_MG4    = 6'd22; // unlink prev block if free
  localparam logic [5:0] S_MG5    = 6'd23;
  localparam logic [5:0] S_MG6    = 6'd24; // unlink next block if free
  localparam logic [5:0] S_MG7    = 6'd25;
  localparam logic [5:0] S_MG8    = 6'd26; // set tags
  localparam logic [5:0] S_MG9    = 6'd27;
  localparam logic [5:0] S_PS0    = 6'd28; // push
  localparam logic [5:0] S_PS1    = 6'd29;
  localparam logic [5:0] S_PS2    = 6'd30;
  localparam logic [5:0] S_UL0    = 6'd31; // unlink: read prev
  localparam logic [5:0] S_UL1    = 6'd32; // read next
  localparam logic [5:0] S_UL2    = 6'd33;
  localparam logic [5:0] S_UL3    = 6'd34;
  localparam logic [5:0] S_UL4    = 6'd35;
  localparam logic [5:0] S_RSP    = 6'd36;

  // unlink return points
  localparam logic [1:0] RetTake = 2'd0;
  localparam logic [1:0] RetPrev = 2'd1;
  localparam logic [1:0] RetNext = 2'd2;

  // push return points
  localparam logic ToWalk = 1'b0;
  localparam logic ToRsp  = 1'b1;

  logic [5:0]  state_q, state_d;
  logic        ready_q, ready_d;
  logic [31:0] head_q, head_d;
  logic [31:0] need_q, need_d;
  logic [31:0] n_q, n_d;          // current block / block being handled
  logic [31:0] have_q, have_d;    // size of n
  logic [31:0] pp_q, pp_d;        // unlink prev
  logic [31:0] nn_q, nn_d;        // unlink next / merge next
  logic [31:0] ub_q, ub_d;        // block being unlinked
  logic [31:0] pf_q, pf_d;        // prev footer word
  logic [31:0] pb_q, pb_d;        // push block
  logic [1:0]  uret_q, uret_d;
  logic        pret_q, pret_d;
  logic        pfree_q, pfree_d;
  logic        nfree_q, nfree_d;
  logic [StepW-1:0] steps_q, steps_d;
  bta_rsp_t    rsp_q, rsp_d;

  logic [31:0] req_need;
  logic [31:0] rd;
  assign rd = sts_i.rdata;

  always_comb begin
    req_need = (32'(req_i.request_bytes) + Wb2 + Wb - 32'd1) & WMask;
    if (req_need < MinB) begin
      req_need = MinB;
    end
  end

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q; ready_d = ready_q; head_d = head_q; need_d = need_q;
    n_d = n_q; have_d = have_q; pp_d = pp_q; nn_d = nn_q; ub_d = ub_q;
    pf_d = pf_q; pb_d = pb_q; uret_d = uret_q; pret_d = pret_q;
    pfree_d = pfree_q; nfree_d = nfree_q; steps_d = steps_q; rsp_d = rsp_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          rsp_d.payload_address = 16'd0;
          rsp_d.status = StDone;
          if (req_i.opcode == OpAlloc) begin
            need_d = req_need;
            steps_d = '0;
            if (req_i.request_bytes == 16'd0) begin
              rsp_d.status = StZero;
              state_d = S_RSP;
            end else if (!ready_q) begin
              ready_d = 1'b1;
              head_d = 32'd0;
              state_d = (Total < MinB) ? S_RSP : S_FMT0;
              if (Total < MinB) rsp_d.status = StNoFit;
            end else begin
              n_d = head_q;
              state_d = S_WLK0;
            end
          end else if (req_i.release_address != 16'd0) begin
            n_d = 32'(req_i.release_address);
            state_d = S_RL0;
          end else begin
            state_d = S_RSP;
          end
        end
      end
      S_FMT0: begin
        cmd_o.wr = 1'b1; cmd_o.addr = 32'd0; cmd_o.data = Total;
        state_d = S_FMT1;
      end
      S_FMT1: begin
        cmd_o.wr = 1'b1; cmd_o.addr = Total - Wb; cmd_o.data = Total;
        pb_d = Wb; pret_d = ToWalk;
        state_d = S_PS0;
      end
      S_WLK0: begin
        if (n_q == 32'd0 || steps_q > StepW'(HeapWords)) begin
          rsp_d.status = StNoFit;
          state_d = S_RSP;
        end else begin
          cmd_o.rd = 1'b1; cmd_o.addr = n_q - Wb;
          state_d = S_WLK1;
        end
      end
      S_WLK1: begin
        have_d = rd & ~32'd1;
        if ((rd & ~32'd1) >= need_q) begin
          ub_d = n_q; uret_d = RetTake;
          state_d = S_UL0;
        end else begin
          cmd_o.rd = 1'b1; cmd_o.addr = n_q + Wb;
          state_d = S_WLK2;
        end
      end
      S_WLK2: begin
        n_d = rd;
        steps_d = steps_q + StepW'(1);
        state_d = S_WLK0;
      end
      S_TK3: begin
        if (have_q - need_q >= MinB) begin
          cmd_o.wr = 1'b1; cmd_o.addr = n_q - Wb; cmd_o.data = need_q | 32'd1;
          state_d = S_TK4;
        end else begin
          cmd_o.wr = 1'b1; cmd_o.addr = n_q - Wb; cmd_o.data = have_q | 32'd1;
          state_d = S_TK6;
        end
      end
      S_TK4: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q + need_q - Wb2;
        cmd_o.data = need_q | 32'd1;
        state_d = S_TK5;
      end
      S_TK5: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q + need_q - Wb;
        cmd_o.data = have_q - need_q;
        state_d = S_TK0;
      end
      S_TK0: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q + have_q - Wb2;
        cmd_o.data = have_q - need_q;
        pb_d = n_q + need_q; pret_d = ToRsp;
        rsp_d.payload_address = n_q[15:0];
        state_d = S_PS0;
      end
      S_TK6: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q + have_q - Wb2;
        cmd_o.data = have_q | 32'd1;
        rsp_d.payload_address = n_q[15:0];
        state_d = S_RSP;
      end
      // release: rewrite tags as free
      S_RL0: begin
        cmd_o.rd = 1'b1; cmd_o.addr = n_q - Wb;
        state_d = S_RL1;
      end
      S_RL1: begin
        have_d = rd & ~32'd1;
        cmd_o.wr = 1'b1; cmd_o.addr = n_q - Wb; cmd_o.data = rd & ~32'd1;
        state_d = S_RL2;
      end
      S_RL2: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q + have_q - Wb2; cmd_o.data = have_q;
        state_d = S_MG0;
      end
      S_MG0: begin
        cmd_o.rd = 1'b1; cmd_o.addr = n_q - Wb;
        state_d = S_MG1;
      end
      S_MG1: begin
        have_d = rd & ~32'd1;
        nn_d = n_q + (rd & ~32'd1);
        cmd_o.rd = 1'b1; cmd_o.addr = n_q - Wb2;
        state_d = S_MG2;
      end
      S_MG2: begin
        pf_d = rd;
        pfree_d = (n_q >= Wb2) && (rd[0] == 1'b0);
        cmd_o.rd = 1'b1; cmd_o.addr = nn_q - Wb;
        state_d = S_MG3;
      end
      S_MG3: begin
        nfree_d = ({1'b0, n_q} + {1'b0, have_q} <= {1'b0, HBytes}) && (rd[0] == 1'b0);
        state_d = S_MG4;
      end
      S_MG4: begin
        if (pfree_q) begin
          ub_d = n_q - (pf_q & ~32'd1); uret_d = RetPrev;
          state_d = S_UL0;
        end else begin
          state_d = S_MG6;
        end
      end
      S_MG5: begin
        // read prev block size after unlink
        cmd_o.rd = 1'b1; cmd_o.addr = ub_q - Wb;
        state_d = S_MG7;
      end
      S_MG7: begin
        have_d = have_q + (rd & ~32'd1);
        n_d = ub_q;
        state_d = S_MG6;
      end
      S_MG6: begin
        if (nfree_q) begin
          ub_d = nn_q; uret_d = RetNext; nfree_d = 1'b0;
          state_d = S_UL0;
        end else begin
          state_d = S_MG8;
        end
      end
      S_TK1: begin
        cmd_o.rd = 1'b1; cmd_o.addr = ub_q - Wb;
        state_d = S_TK2;
      end
      S_TK2: begin
        have_d = have_q + (rd & ~32'd1);
        state_d = S_MG8;
      end
      S_MG8: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q - Wb; cmd_o.data = have_q;
        state_d = S_MG9;
      end
      S_MG9: begin
        cmd_o.wr = 1'b1; cmd_o.addr = n_q + have_q - Wb2; cmd_o.data = have_q;
        pb_d = n_q; pret_d = ToRsp;
        state_d = S_PS0;
      end
      // list push of pb
      S_PS0: begin
        cmd_o.wr = 1'b1; cmd_o.addr = pb_q; cmd_o.data = 32'd0;
        state_d = S_PS1;
      end
      S_PS1: begin
        cmd_o.wr = 1'b1; cmd_o.addr = pb_q + Wb; cmd_o.data = head_q;
        state_d = S_PS2;
      end
      S_PS2: begin
        if (head_q != 32'd0) begin
          cmd_o.wr = 1'b1; cmd_o.addr = head_q; cmd_o.data = pb_q;
        end
        head_d = pb_q;
        if (pret_q == ToWalk) begin
          n_d = pb_q;
          state_d = S_WLK0;
        end else begin
          state_d = S_RSP;
        end
      end
      // list unlink of ub
      S_UL0: begin
        cmd_o.rd = 1'b1; cmd_o.addr = ub_q;
        state_d = S_UL1;
      end
      S_UL1: begin
        pp_d = rd;
        cmd_o.rd = 1'b1; cmd_o.addr = ub_q + Wb;
        state_d = S_UL2;
      end
      S_UL2: begin
        if (pp_q != 32'd0) begin
          cmd_o.wr = 1'b1; cmd_o.addr = pp_q + Wb; cmd_o.data = rd;
        end else begin
          head_d = rd;
        end
        pf_d = rd; // reuse as link next
        state_d = S_UL3;
      end
      S_UL3: begin
        if (pf_q != 32'd0) begin
          cmd_o.wr = 1'b1; cmd_o.addr = pf_q; cmd_o.data = pp_q;
        end
        state_d = S_UL4;
      end
      S_UL4: begin
        case (uret_q)
          RetTake: state_d = S_TK3;
          RetPrev: state_d = S_MG5;
          RetNext: state_d = S_TK1;
          default: state_d = S_RSP;
        endcase
      end
      S_RSP: begin
        if (!rsp_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      head_q  <= 32'd0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d; n_q <= n_d; have_q <= have_d; pp_q <= pp_d;
    nn_q <= nn_d; ub_q <= ub_d; pf_q <= pf_d; pb_q <= pb_d;
    uret_q <= uret_d; pret_q <= pret_d; pfree_q <= pfree_d;
    nfree_q <= nfree_d; steps_q <= steps_d; rsp_q <= rsp_d;
  end
endmodule

// ===== sv/boundary_tag_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator: first fit explicit free list allocator
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid_i/stall_o | bta_req_t
//   rsp     | out       | rsp_valid_o/stall_i | bta_rsp_t
//
// One request at a time, at most one heap word access per cycle on a single-port RAM.
// Allocate: walks the free list node by node, then takes the first block that fits,
// splitting it when the rest is big enough; the first allocate formats the heap.
// Release: rewrites the tags as free, merges each free neighbour, pushes the block.
// Zero size and null release go straight to the result; the result appears
// the cycle after the last step, and req_stall_o stays high until it leaves.
// Reset clears state, list head and format flag only; no memory clearing pass.
// The result holds in the output register while rsp_stall_i is high.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
  parameter int unsigned HeapBytes = bta_pkg::HeapBytesDef,
  parameter int unsigned WordBytes = bta_pkg::WordBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_stall_o,
  input  bta_pkg::bta_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_stall_i,
  output bta_pkg::bta_rsp_t rsp_o
);
  import bta_pkg::*;

  bta_mem_cmd_t cmd;
  bta_mem_sts_t sts;

  bta_ctrl #(.HeapBytes(HeapBytes), .WordBytes(WordBytes)) u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  bta_datapath #(.HeapBytes(HeapBytes), .WordBytes(WordBytes)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts)
  );
endmodule

// ===== sv/bta_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_checker: port level checks for the allocator
// Watches handshakes and result codes.
// ----------------------------------------------------------------------------
module bta_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_stall_o,
  input logic              rsp_valid_o,
  input logic              rsp_stall_i,
  input bta_pkg::bta_rsp_t rsp_o
);
  import bta_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_stall_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result dropped while stalled");

  a_no_req_while_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o)
    else $error("request taken while a result is pending");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == StDone || rsp_o.status == StNoFit ||
                     rsp_o.status == StZero))
    else $error("bad status code");

  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != StDone |-> rsp_o.payload_address == 16'd0)
    else $error("failed request returned an address");
endmodule

bind boundary_tag_heap_allocator bta_checker u_bta_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .rsp_valid_o, .rsp_stall_i, .rsp_o
);

// ===== bench/boundary_tag_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_tb: self-checking bench for the heap allocator
// A directed table followed by random allocate/release traffic. The releases
// target live grants or the null address. Typed rows are checked against the table,
// all others against an in-bench model of the tag heap, under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_tb;
  import bta_pkg::*;

  localparam int unsigned HeapWords = HeapBytesDef / WordBytesDef;
  localparam int unsigned Wb = WordBytesDef;
  localparam int unsigned MinBlk = 4 * WordBytesDef;
  localparam logic [31:0] AllocBit = 32'h1;
  localparam int unsigned RandItems = 850;
  localparam longint CycleLimit = 1500000;

  typedef struct {
    logic        op;
    logic [15:0] bytes;
    logic [15:0] addr;
    int          pick;     // >= 0: release the live grant with this index
    bit          typed;
    logic [15:0] exp_addr;
    logic [1:0]  exp_st;
  } row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_stall_o;
  bta_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_stall_i = 1'b0;
  bta_rsp_t rsp_o;

  boundary_tag_heap_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  // model state of the heap
  logic [31:0] heap_mem [HeapWords];
  int unsigned list_head;
  bit          formatted;

  bta_rsp_t    pending_rsp [$];
  logic [15:0] live_grants [$];
  int          mismatches = 0;
  longint      cycles = 0;
  int          idle_pct;
  int          stall_pct;
  int          hold_len = 0;
  int          hold_cycles = 0;

  function automatic logic [31:0] heap_rd(int unsigned a);
    int unsigned i;
    i = a / Wb;
    return (i < HeapWords) ? heap_mem[i] : 32'h0;
  endfunction

  function automatic void heap_wr(int unsigned a, logic [31:0] v);
    int unsigned i;
    i = a / Wb;
    if (i < HeapWords) heap_mem[i] = v;
  endfunction

  function automatic int unsigned block_bytes(int unsigned bp);
    return heap_rd(bp - Wb) & ~AllocBit;
  endfunction

  function automatic void write_tags(int unsigned bp, int unsigned sz, logic [31:0] al);
    heap_wr(bp - Wb, sz | al);
    heap_wr(bp + sz - 2 * Wb, sz | al);
  endfunction

  function automatic void push_free(int unsigned bp);
    heap_wr(bp, 0);
    heap_wr(bp + Wb, list_head);
    if (list_head != 0) heap_wr(list_head, bp);
    list_head = bp;
  endfunction

  function automatic void unlink_free(int unsigned bp);
    int unsigned p, n;
    p = heap_rd(bp);
    n = heap_rd(bp + Wb);
    if (p != 0) heap_wr(p + Wb, n);
    else list_head = n;
    if (n != 0) heap_wr(n, p);
  endfunction

  function automatic int unsigned coalesce(int unsigned bp_in);
    int unsigned bp, sz, nxt, pb;
    bit pf, nf;
    bp = bp_in;
    sz = block_bytes(bp);
    nxt = bp + sz;
    pf = 0;
    nf = 0;
    if (bp >= 2 * Wb) pf = (heap_rd(bp - 2 * Wb) & AllocBit) == 0;
    if (longint'(bp) + sz <= longint'(HeapBytesDef)) nf = (heap_rd(nxt - Wb) & AllocBit) == 0;
    if (pf) begin
      pb = bp - (heap_rd(bp - 2 * Wb) & ~AllocBit);
      unlink_free(pb);
      sz += block_bytes(pb);
      bp = pb;
    end
    if (nf) begin
      unlink_free(nxt);
      sz += block_bytes(nxt);
    end
    write_tags(bp, sz, 0);
    return bp;
  endfunction

  function automatic bta_rsp_t heap_step(bta_req_t r);
    bta_rsp_t    o;
    int unsigned need, n, steps, have, sz;
    o.payload_address = '0;
    o.status = StDone;
    if (r.opcode == OpAlloc) begin
      if (r.request_bytes == 0) begin
        o.status = StZero;
      end else begin
        if (!formatted) begin
          formatted = 1;
          list_head = 0;
          write_tags(Wb, HeapWords * Wb, 0);
          push_free(Wb);
        end
        need = (r.request_bytes + 2 * Wb + Wb - 1) / Wb * Wb;
        if (need < MinBlk) need = MinBlk;
        o.status = StNoFit;
        n = list_head;
        for (steps = 0; n != 0 && steps <= HeapWords; steps++) begin
          have = block_bytes(n);
          if (have >= need) begin
            unlink_free(n);
            if (have - need >= MinBlk) begin
              write_tags(n, need, AllocBit);
              write_tags(n + need, have - need, 0);
              push_free(n + need);
            end else begin
              write_tags(n, have, AllocBit);
            end
            o.payload_address = n[15:0];
            o.status = StDone;
            break;
          end
          n = heap_rd(n + Wb);
        end
      end
    end else if (r.release_address != 0) begin
      sz = block_bytes(r.release_address);
      write_tags(r.release_address, sz, 0);
      push_free(coalesce(r.release_address));
    end
    return o;
  endfunction

  // offer one request, wait for acceptance, then record what must come back
  task automatic offer(bta_req_t r, bit typed, bta_rsp_t typed_rsp);
    bta_rsp_t p;
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    p = heap_step(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    if (r.opcode == OpAlloc && p.status == StDone) live_grants.push_back(p.payload_address);
    @(negedge clk_i);
  endtask

  task automatic send_row(row_t w);
    bta_req_t r;
    bta_rsp_t e;
    r.opcode = w.op;
    r.request_bytes = w.bytes;
    r.release_address = w.addr;
    if (w.pick >= 0 && w.pick < live_grants.size()) begin
      r.release_address = live_grants[w.pick];
      live_grants.delete(w.pick);
    end
    e.payload_address = w.exp_addr;
    e.status = w.exp_st;
    offer(r, w.typed, e);
  endtask

  task automatic send_random();
    bta_req_t r;
    bta_rsp_t e;
    int       k, i;
    e = '0;
    k = $urandom_range(0, 99);
    r.request_bytes = 16'($urandom);
    r.release_address = 16'($urandom);
    if (live_grants.size() > 60 && k < 55) k = 70;
    if (k < 55 || live_grants.size() == 0) begin
      r.opcode = OpAlloc;
      k = $urandom_range(0, 99);
      if (k < 70) r.request_bytes = 16'($urandom_range(1, 256));
      else if (k < 88) r.request_bytes = 16'($urandom_range(257, 4096));
      else if (k < 94) r.request_bytes = 16'($urandom_range(4097, 65535));
      else if (k < 97) r.request_bytes = 16'hFFFF;
      else r.request_bytes = '0;
    end else begin
      r.opcode = OpRelease;
      if (k < 95) begin
        i = $urandom_range(0, live_grants.size() - 1);
        r.release_address = live_grants[i];
        live_grants.delete(i);
      end else begin
        r.release_address = '0;
      end
    end
    offer(r, 1'b0, e);
  endtask

  row_t directed [] = '{
    '{OpAlloc,   16'd0,     16'hFFFF, -1, 1, 16'd0, StZero},
    '{OpRelease, 16'hFFFF,  16'd0,    -1, 1, 16'd0, StDone},
    '{OpAlloc,   16'd1,     16'd0,    -1, 1, 16'd4, StDone},
    '{OpAlloc,   16'hFFFF,  16'hFFFF, -1, 1, 16'd0, StNoFit},
    '{OpRelease, 16'd0,     16'd0,     0, 1, 16'd0, StDone},
    '{OpAlloc,   16'd65528, 16'd0,    -1, 1, 16'd4, StDone},
    '{OpAlloc,   16'd1,     16'd0,    -1, 1, 16'd0, StNoFit},
    '{OpRelease, 16'd0,     16'd0,     0, 1, 16'd0, StDone},
    '{OpAlloc,   16'd100,   16'd0,    -1, 0, 16'd0, StDone},
    '{OpAlloc,   16'd200,   16'd0,    -1, 0, 16'd0, StDone},
    '{OpAlloc,   16'd300,   16'd0,    -1, 0, 16'd0, StDone},
    '{OpAlloc,   16'd40,    16'd0,    -1, 0, 16'd0, StDone},
    '{OpAlloc,   16'd9,     16'd0,    -1, 0, 16'd0, StDone},
    '{OpRelease, 16'd0,     16'd0,     0, 1, 16'd0, StDone},
    '{OpRelease, 16'd0,     16'd0,     1, 1, 16'd0, StDone},
    '{OpRelease, 16'd0,     16'd0,     0, 1, 16'd0, StDone},
    '{OpAlloc,   16'd7,     16'd0,    -1, 0, 16'd0, StDone},
    '{OpAlloc,   16'd500,   16'd0,    -1, 0, 16'd0, StDone},
    '{OpAlloc,   16'd64000, 16'd0,    -1, 0, 16'd0, StDone},
    '{OpRelease, 16'd0,     16'd0,     2, 1, 16'd0, StDone},
    '{OpRelease, 16'd0,     16'd0,     0, 1, 16'd0, StDone},
    '{OpAlloc,   16'd12,    16'd0,    -1, 0, 16'd0, StDone}
  };

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls plus a counted long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles < hold_len) begin
      rsp_stall_i <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      rsp_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    bta_rsp_t e;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result addr=%0d st=%0d",
                                       rsp_o.payload_address, rsp_o.status);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.payload_address !== e.payload_address || rsp_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp addr=%0d st=%0d, got addr=%0d st=%0d",
                                         e.payload_address, e.status,
                                         rsp_o.payload_address, rsp_o.status);
        end
      end
    end
  end

  initial begin
    int n;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    list_head = 0;
    formatted = 0;
    foreach (heap_mem[i]) heap_mem[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_row(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      // long receiver hold-off while requests keep coming
      if (ph == 1) hold_len = 600;
      for (n = 0; n < RandItems / 4; n++) begin
        send_random();
      end
      // sender pause until everything has drained
      req_valid_i <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clk_i);
    end

    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
